/* src/xsgc_pkg.sv */
// Shared constants and helpers for the XYZ to linear sRGB converter.
// No dependencies; used by the core and its checker.
package xsgc_pkg;

   localparam int IN_WIDTH_DEF       = 24;
   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam int OUT_WIDTH          = 28;

   // Channel fraction bits (input and output are both .20)
   localparam int CH_FRAC_BITS = 20;

   // Matrix coefficients in units of 1e-7, row major (R, G, B rows; X, Y, Z columns)
   localparam longint DEC_SCALE = 64'sd10000000;
   localparam longint COEF_DEC [9] = '{
       64'sd32404542, -64'sd15371385,  -64'sd4985314,
       -64'sd9692660,  64'sd18760108,    64'sd415560,
         64'sd556434,  -64'sd2040259,  64'sd10572252
   };

   // Fixed-point coefficient, magnitude rounded half away from zero
   function automatic longint qcoef(input longint k, input int frac);
      longint mag;
      longint q;
      mag = (k < 0) ? -k : k;
      q   = ((mag <<< frac) + DEC_SCALE / 2) / DEC_SCALE;
      return (k < 0) ? -q : q;
   endfunction

endpackage

/* src/xyz_to_srgb_gamut_clamp_core.sv */
// Accepts one request per cycle while the output is not stalled by rsp_ready.
// Five register stages: input, matrix products, rounded row sums, min/clamp amount,
// saturated output. Each stage fills bubbles independently, so a stalled result does not
// block new requests while earlier stages are empty.
// Reset: synchronous, active high; clears stage valids and sets clamp enable to 1.
// Depends on xsgc_pkg.
module xyz_to_srgb_gamut_clamp_core #(
   parameter int IN_WIDTH       = xsgc_pkg::IN_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = xsgc_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [IN_WIDTH-1:0]            req_in_x,
   input  logic signed [IN_WIDTH-1:0]            req_in_y,
   input  logic signed [IN_WIDTH-1:0]            req_in_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [xsgc_pkg::OUT_WIDTH-1:0] rsp_out_r,
   output logic signed [xsgc_pkg::OUT_WIDTH-1:0] rsp_out_g,
   output logic signed [xsgc_pkg::OUT_WIDTH-1:0] rsp_out_b,
   output logic                                  rsp_out_of_gamut
);

   localparam int OW   = xsgc_pkg::OUT_WIDTH;
   localparam int CW   = COEF_FRAC_BITS + 3;
   localparam int PW   = CW + IN_WIDTH;
   localparam int SUMW = PW + 2;
   localparam int CHW  = SUMW - COEF_FRAC_BITS;
   localparam int DW   = CHW + 1;
   localparam int WW   = (DW > OW) ? DW : OW;
   localparam logic signed [SUMW-1:0] HALF_LSB = SUMW'(longint'(1) <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [WW-1:0]   SAT_HI   = WW'((longint'(1) <<< (OW - 1)) - 1);
   localparam logic signed [WW-1:0]   SAT_LO   = WW'(-(longint'(1) <<< (OW - 1)));

   // Stage enables
   logic en_a, en_b, en_c, en_d, en_e;
   logic vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff, vld_e_ff;

   logic clamp_en_ff;

   logic signed [IN_WIDTH-1:0] xyz_ff [3];
   logic signed [PW-1:0]       prod_in [9];
   logic signed [PW-1:0]       prod_ff [9];
   logic signed [CHW-1:0]      ch_in [3];
   logic signed [CHW-1:0]      ch_c_ff [3];
   logic signed [CHW-1:0]      ch_d_ff [3];
   logic signed [CHW-1:0]      min_val;
   logic signed [CHW-1:0]      sub_in;
   logic signed [CHW-1:0]      sub_ff;
   logic                       oog_in;
   logic                       oog_d_ff;
   logic signed [OW-1:0]       out_in [3];
   logic signed [OW-1:0]       out_ff [3];
   logic                       oog_e_ff;

   assign en_e = !vld_e_ff || rsp_ready;
   assign en_d = !vld_d_ff || en_e;
   assign en_c = !vld_c_ff || en_d;
   assign en_b = !vld_b_ff || en_c;
   assign en_a = !vld_a_ff || en_b;
   assign req_ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_en_ff <= 1'b1;
         vld_a_ff    <= 1'b0;
         vld_b_ff    <= 1'b0;
         vld_c_ff    <= 1'b0;
         vld_d_ff    <= 1'b0;
         vld_e_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            clamp_en_ff <= csr_wr_data;
         end
         if (en_a) vld_a_ff <= req_valid;
         if (en_b) vld_b_ff <= vld_a_ff;
         if (en_c) vld_c_ff <= vld_b_ff;
         if (en_d) vld_d_ff <= vld_c_ff;
         if (en_e) vld_e_ff <= vld_d_ff;
      end
   end

   // Stage A: input register
   always_ff @(posedge clock) begin
      if (en_a && req_valid) begin
         xyz_ff[0] <= req_in_x;
         xyz_ff[1] <= req_in_y;
         xyz_ff[2] <= req_in_z;
      end
   end

   // Stage B: one multiplier per matrix entry
   for (genvar g = 0; g < 9; g++) begin : g_mult
      localparam logic signed [CW-1:0] K =
         CW'(xsgc_pkg::qcoef(xsgc_pkg::COEF_DEC[g], COEF_FRAC_BITS));
      assign prod_in[g] = PW'(xyz_ff[g % 3]) * PW'(K);
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         prod_ff <= prod_in;
      end
   end

   // Stage C: row sums, round half up back to .20
   always_comb begin
      logic signed [SUMW-1:0] sum;
      for (int i = 0; i < 3; i++) begin
         sum = SUMW'(prod_ff[3*i]) + SUMW'(prod_ff[3*i+1]) + SUMW'(prod_ff[3*i+2]) + HALF_LSB;
         ch_in[i] = sum[SUMW-1:COEF_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         ch_c_ff <= ch_in;
      end
   end

   // Stage D: smallest channel decides gamut flag and shift toward white
   always_comb begin
      min_val = ch_c_ff[0];
      if (ch_c_ff[1] < min_val) min_val = ch_c_ff[1];
      if (ch_c_ff[2] < min_val) min_val = ch_c_ff[2];
      oog_in = min_val[CHW-1];
      sub_in = (oog_in && clamp_en_ff) ? min_val : '0;
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         ch_d_ff  <= ch_c_ff;
         sub_ff   <= sub_in;
         oog_d_ff <= oog_in;
      end
   end

   // Stage E: apply clamp, saturate to Q7.20
   always_comb begin
      logic signed [DW-1:0] diff;
      logic signed [WW-1:0] wide;
      for (int i = 0; i < 3; i++) begin
         diff = DW'(ch_d_ff[i]) - DW'(sub_ff);
         wide = WW'(diff);
         if (wide > SAT_HI) begin
            out_in[i] = OW'(SAT_HI);
         end else if (wide < SAT_LO) begin
            out_in[i] = OW'(SAT_LO);
         end else begin
            out_in[i] = OW'(wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         out_ff   <= out_in;
         oog_e_ff <= oog_d_ff;
      end
   end

   assign rsp_valid        = vld_e_ff;
   assign rsp_out_r        = out_ff[0];
   assign rsp_out_g        = out_ff[1];
   assign rsp_out_b        = out_ff[2];
   assign rsp_out_of_gamut = oog_e_ff;

endmodule

/* src/xsgc_chk.sv */
// Port-level checker for xyz_to_srgb_gamut_clamp_core, bound to every instance of the core.
// Depends on xsgc_pkg.
module xsgc_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  csr_wr_en,
   input logic                                  csr_wr_data,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [xsgc_pkg::OUT_WIDTH-1:0] rsp_out_r,
   input logic signed [xsgc_pkg::OUT_WIDTH-1:0] rsp_out_g,
   input logic signed [xsgc_pkg::OUT_WIDTH-1:0] rsp_out_b,
   input logic                                  rsp_out_of_gamut
);

   localparam int SB = xsgc_pkg::OUT_WIDTH - 1;

   // Shadow of the clamp enable register as seen on the write port
   logic clamp_shadow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_shadow_ff <= 1'b1;
      end else if (csr_wr_en) begin
         clamp_shadow_ff <= csr_wr_data;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_r) && $stable(rsp_out_g)
         && $stable(rsp_out_b) && $stable(rsp_out_of_gamut))
      else $error("stalled response changed or dropped");

   a_in_gamut_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_gamut |-> !rsp_out_r[SB] && !rsp_out_g[SB] && !rsp_out_b[SB])
      else $error("negative channel without out-of-gamut flag");

   a_clamped_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_gamut && clamp_shadow_ff
         |-> !rsp_out_r[SB] && !rsp_out_g[SB] && !rsp_out_b[SB])
      else $error("clamped response still has a negative channel");

   a_raw_keeps_negative: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_gamut && !clamp_shadow_ff
         |-> rsp_out_r[SB] || rsp_out_g[SB] || rsp_out_b[SB])
      else $error("out-of-gamut flag set but no negative channel with clamp off");

endmodule

bind xyz_to_srgb_gamut_clamp_core xsgc_chk u_xsgc_chk (
   .clock            (clock),
   .reset            (reset),
   .csr_wr_en        (csr_wr_en),
   .csr_wr_data      (csr_wr_data),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_r        (rsp_out_r),
   .rsp_out_g        (rsp_out_g),
   .rsp_out_b        (rsp_out_b),
   .rsp_out_of_gamut (rsp_out_of_gamut)
);
